[hw/rtl/mfcsm_pkg.sv]
// Package with shared types and constants of the four-voice sample mixer.
package mfcsm_pkg;

	localparam int SAMPLE_MEM_DEPTH_DEF = 65536;
	localparam int NUM_VOICES_DEF       = 4;
	localparam int NUM_INSTRUMENTS_DEF  = 31;

	localparam logic [23:0] INC_NUMERATOR = 24'd10638960;
	localparam logic [6:0]  VOL_MAX       = 7'd64;
	localparam logic [3:0]  EFF_PORTA     = 4'h3;
	localparam logic [3:0]  EFF_SET_VOL   = 4'hC;
	localparam int          QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_HEADER = 2'd1,
		FUNC_NOTE   = 2'd2,
		FUNC_GEN    = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] addr;
		logic [7:0]  data_byte;
		logic [4:0]  instrument;
		logic [16:0] inst_length;
		logic [16:0] loop_start;
		logic [16:0] loop_length;
		logic [6:0]  default_volume;
		logic [1:0]  channel;
		logic [11:0] period;
		logic [3:0]  effect;
		logic [7:0]  param;
	} req_t;

endpackage

[hw/rtl/mod_four_channel_sample_mixer_top.sv]
// Top level of the four-voice sample mixer: request queue, back-end sequencer.
// A generate request passes the fetch, read and accumulate states per voice, then ST_OUT.
// The back part takes one request at a time; a note with a new period waits in ST_DIV for
// the 24-step increment divider, while loads and other notes skip it.
// Reset clears the queue, instrument table and voice state; sample memory is not cleared.
// A two-entry queue lets requests be accepted while the back part is busy.
module mod_four_channel_sample_mixer_top
	import mfcsm_pkg::*;
#(
	parameter int SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF,
	parameter int NUM_VOICES       = NUM_VOICES_DEF,
	parameter int NUM_INSTRUMENTS  = NUM_INSTRUMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [15:0]        addr,
	input  logic signed [7:0]  data_byte,
	input  logic [4:0]         instrument,
	input  logic [16:0]        inst_length,
	input  logic [16:0]        loop_start,
	input  logic [16:0]        loop_length,
	input  logic [6:0]         default_volume,
	input  logic [1:0]         channel,
	input  logic [11:0]        period,
	input  logic [3:0]         effect,
	input  logic [7:0]         param,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] mixed_sample
);

	req_t in_req, q_req;
	logic q_valid, q_take;

	// Pack the request fields for the queue.
	always_comb begin
		in_req                = '0;
		in_req.func           = func_t'(func);
		in_req.addr           = addr;
		in_req.data_byte      = data_byte;
		in_req.instrument     = instrument;
		in_req.inst_length    = inst_length;
		in_req.loop_start     = loop_start;
		in_req.loop_length    = loop_length;
		in_req.default_volume = default_volume;
		in_req.channel        = channel;
		in_req.period         = period;
		in_req.effect         = effect;
		in_req.param          = param;
	end

	mfcsm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
	);

	mfcsm_back #(
		.SAMPLE_MEM_DEPTH(SAMPLE_MEM_DEPTH),
		.NUM_VOICES(NUM_VOICES),
		.NUM_INSTRUMENTS(NUM_INSTRUMENTS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take), .q_req(q_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_sample(mixed_sample)
	);

endmodule

[hw/rtl/mfcsm_front.sv]
// Front part: accepts requests and holds them in a short queue for the back part.
module mfcsm_front
	import mfcsm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_req,
	output logic q_valid,
	input  logic q_take,
	output req_t q_req
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	req_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign in_stall = (cnt_q == (PW+1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != '0;
	assign pop      = q_valid && q_take;
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
		end
	end

endmodule

[hw/rtl/mfcsm_div.sv]
// Restoring divider that computes the 24-bit phase increment from a 12-bit period.
module mfcsm_div
	import mfcsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [11:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);

	logic [23:0] quo_q;
	logic [12:0] rem_q;
	logic [11:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [12:0] trial;
	logic [12:0] shifted;

	assign shifted  = {rem_q[11:0], quo_q[23]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= INC_NUMERATOR;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[12]) begin
				rem_q <= trial;
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd23;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

endmodule

[hw/rtl/mfcsm_back.sv]
// Back part: sample memory, instrument table, voice state and the mixing sequencer.
module mfcsm_back
	import mfcsm_pkg::*;
#(
	parameter int SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF,
	parameter int NUM_VOICES       = NUM_VOICES_DEF,
	parameter int NUM_INSTRUMENTS  = NUM_INSTRUMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  req_t               q_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_sample
);

	localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_VSET  = 7'b0000100,
		ST_FETCH = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_ACC   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic signed [7:0] smem [SAMPLE_MEM_DEPTH];
	logic signed [7:0] rd_data_q;
	logic [AW-1:0]     rd_addr;

	logic [15:0] ibase_q [NUM_INSTRUMENTS];
	logic [16:0] ilen_q  [NUM_INSTRUMENTS];
	logic [16:0] ilps_q  [NUM_INSTRUMENTS];
	logic [16:0] illn_q  [NUM_INSTRUMENTS];
	logic [6:0]  ivol_q  [NUM_INSTRUMENTS];

	logic [11:0] cper_q [NUM_VOICES];
	logic [4:0]  cins_q [NUM_VOICES];
	logic [6:0]  cvol_q [NUM_VOICES];
	logic [32:0] cpos_q [NUM_VOICES];
	logic [23:0] cinc_q [NUM_VOICES];

	req_t        cur_q;
	logic [VW-1:0] vox_q;
	logic signed [18:0] mix_q;
	logic signed [15:0] out_q;
	logic        out_valid_q;

	// Per-voice fetched header, registered in ST_FETCH.
	logic        act_q;
	logic [16:0] len_q, lps_q, lln_q;
	logic [32:0] pos_q;
	logic [6:0]  vol_q;

	logic        div_start, div_done;
	logic [23:0] div_quo;

	logic        ins_ok_req, ch_ok;
	logic [4:0]  ik_req;
	logic [4:0]  cur_ins;
	logic [4:0]  cur_k;
	logic        cur_ins_ok;

	logic signed [14:0] prod;
	logic signed [14:0] absq;
	logic signed [8:0]  q;
	logic [33:0] nxt;
	logic [17:0] lend;

	assign ins_ok_req = (q_req.instrument != 5'd0) &&
		({1'b0, q_req.instrument} <= 6'(NUM_INSTRUMENTS));
	assign ik_req = q_req.instrument - 5'd1;
	assign ch_ok  = {30'd0, cur_q.channel} < 32'(NUM_VOICES);

	assign cur_ins    = cins_q[vox_q];
	assign cur_k      = cur_ins - 5'd1;
	assign cur_ins_ok = (cur_ins != 5'd0) && ({1'b0, cur_ins} <= 6'(NUM_INSTRUMENTS));

	assign rd_addr = AW'({16'd0, ibase_q[cur_k]} + {15'd0, cpos_q[vox_q][32:16]});

	assign prod = $signed(rd_data_q) * $signed({1'b0, vol_q});
	assign absq = prod[14] ? -prod : prod;
	assign q    = prod[14] ? -$signed({1'b0, absq[13:6]}) : $signed({1'b0, absq[13:6]});
	assign nxt  = {1'b0, pos_q} + {10'd0, cinc_q[vox_q]};
	assign lend = {1'b0, lps_q} + {1'b0, lln_q};

	assign q_take     = (state_q == ST_IDLE) && q_valid;
	assign div_start  = (state_q == ST_IDLE) && q_valid && (q_req.func == FUNC_NOTE) &&
		(q_req.period != 12'd0) && (q_req.effect != EFF_PORTA);
	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

	mfcsm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .divisor(q_req.period),
		.done(div_done), .quotient(div_quo)
	);

	always_ff @(posedge clk) begin
		if (q_take && q_req.func == FUNC_SAMPLE) begin
			smem[AW'(q_req.addr)] <= q_req.data_byte;
		end
		rd_data_q <= smem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vox_q       <= '0;
			mix_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			act_q       <= 1'b0;
			len_q <= '0; lps_q <= '0; lln_q <= '0; pos_q <= '0; vol_q <= '0;
			cur_q <= '0;
			for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
				ibase_q[i] <= '0; ilen_q[i] <= '0; ilps_q[i] <= '0;
				illn_q[i] <= '0; ivol_q[i] <= '0;
			end
			for (int i = 0; i < NUM_VOICES; i++) begin
				cper_q[i] <= '0; cins_q[i] <= '0; cvol_q[i] <= '0;
				cpos_q[i] <= '0; cinc_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_take) begin
						cur_q <= q_req;
						unique case (q_req.func)
							FUNC_SAMPLE: ;
							FUNC_HEADER: begin
								if (ins_ok_req) begin
									ibase_q[ik_req] <= q_req.addr;
									ilen_q[ik_req]  <= q_req.inst_length;
									ilps_q[ik_req]  <= q_req.loop_start;
									illn_q[ik_req]  <= q_req.loop_length;
									ivol_q[ik_req]  <= (q_req.default_volume > VOL_MAX) ?
										VOL_MAX : q_req.default_volume;
								end
							end
							FUNC_NOTE: state_q <= div_start ? ST_DIV : ST_VSET;
							FUNC_GEN: begin
								vox_q   <= '0;
								mix_q   <= '0;
								state_q <= ST_FETCH;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_VSET;
					end
				end
				ST_VSET: begin
					if (ch_ok) begin
						if (cur_q.instrument != 5'd0 &&
							{1'b0, cur_q.instrument} <= 6'(NUM_INSTRUMENTS)) begin
							cins_q[VW'(cur_q.channel)] <= cur_q.instrument;
						end
						if (cur_q.period != 12'd0 && cur_q.effect != EFF_PORTA) begin
							cper_q[VW'(cur_q.channel)] <= cur_q.period;
							cpos_q[VW'(cur_q.channel)] <= '0;
							cinc_q[VW'(cur_q.channel)] <= div_quo;
						end
						// An explicit volume effect wins over the instrument default.
						if (cur_q.effect == EFF_SET_VOL && cur_q.param <= 8'd64) begin
							cvol_q[VW'(cur_q.channel)] <= cur_q.param[6:0];
						end else if (cur_q.instrument != 5'd0 &&
							{1'b0, cur_q.instrument} <= 6'(NUM_INSTRUMENTS)) begin
							cvol_q[VW'(cur_q.channel)] <= ivol_q[cur_q.instrument - 5'd1];
						end
					end
					state_q <= ST_IDLE;
				end
				ST_FETCH: begin
					act_q <= (cper_q[vox_q] != 12'd0) && cur_ins_ok &&
						(ilen_q[cur_k] != 17'd0) && (cpos_q[vox_q][32:16] < ilen_q[cur_k]);
					len_q <= ilen_q[cur_k];
					lps_q <= ilps_q[cur_k];
					lln_q <= illn_q[cur_k];
					pos_q <= cpos_q[vox_q];
					vol_q <= cvol_q[vox_q];
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_ACC;
				ST_ACC: begin
					if (act_q) begin
						mix_q <= mix_q + 19'(q) * 19'sd32;
						if (lln_q > 17'd2) begin
							cpos_q[vox_q] <= ({1'b0, nxt[33:16]} >= {1'b0, lend}) ?
								{lps_q, 16'd0} : nxt[32:0];
						end else if (nxt[33:16] >= {1'b0, len_q}) begin
							cpos_q[vox_q] <= '0;
							cper_q[vox_q] <= '0;
						end else begin
							cpos_q[vox_q] <= nxt[32:0];
						end
					end
					if (32'(vox_q) == NUM_VOICES - 1) begin
						state_q <= ST_OUT;
					end else begin
						vox_q   <= vox_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q <= (mix_q > 19'sd32767) ? 16'sd32767 :
							(mix_q < -19'sd32768) ? -16'sd32768 : mix_q[15:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[bench/mod_four_channel_sample_mixer_top_tb.sv]
// Self-checking testbench for the four-voice sample mixer top level.
module mod_four_channel_sample_mixer_top_tb;
	import mfcsm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// One row of the directed stimulus table. Where chk is set, the mix value is
	// typed in by hand; otherwise the voice predictor supplies it.
	typedef struct {
		req_t             r;
		bit               chk;
		logic signed [15:0] mix;
	} dir_row_t;

	localparam int DIR_ROWS   = 21;
	localparam int RAND_ITEMS = 1830;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] mixed_sample;
	req_t drv = '0;

	// Shared pacing flags: quiet turns off random idling on both sides, and
	// hold_off is the long receiver stall that fills the request queue.
	bit quiet = 1'b0;
	bit hold_off = 1'b0;
	int items_sent = 0;
	int mixes_checked = 0;
	int fail_count = 0;
	int notes_sent = 0;
	int headers_sent = 0;
	int bytes_sent = 0;
	int stall_cycles = 0;

	// Mirror of the block's state, kept by the voice predictor.
	logic signed [7:0] smem [65536];
	bit                smem_written [65536];
	logic [15:0]       ins_base [32];
	logic [16:0]       ins_len [32];
	logic [16:0]       ins_lp [32];
	logic [16:0]       ins_ll [32];
	logic [6:0]        ins_vol [32];
	bit                ins_safe [32];
	logic [11:0]       voice_per [4];
	logic [4:0]        voice_ins [4];
	logic [6:0]        voice_vol [4];
	logic [32:0]       voice_pos [4];
	logic [23:0]       voice_inc [4];

	logic signed [15:0] mix_expect_q [$];

	dir_row_t dir_tab [DIR_ROWS];

	mod_four_channel_sample_mixer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (drv.func),
		.addr           (drv.addr),
		.data_byte      (drv.data_byte),
		.instrument     (drv.instrument),
		.inst_length    (drv.inst_length),
		.loop_start     (drv.loop_start),
		.loop_length    (drv.loop_length),
		.default_volume (drv.default_volume),
		.channel        (drv.channel),
		.period         (drv.period),
		.effect         (drv.effect),
		.param          (drv.param),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mixed_sample   (mixed_sample)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Generous cap on the whole run; a correct run needs well under a tenth of it.
	initial begin
		#20_000_000;
		$display("mod_four_channel_sample_mixer_top_tb NOT OK");
		$finish;
	end

	// Builds one request from the given field values.
	function automatic req_t mk_req(func_t f, logic [15:0] a, logic [7:0] d, logic [4:0] ins,
			logic [16:0] len, logic [16:0] lp, logic [16:0] ll, logic [6:0] vol,
			logic [1:0] ch, logic [11:0] per, logic [3:0] eff, logic [7:0] par);
		req_t r;
		r.func = f;
		r.addr = a;
		r.data_byte = d;
		r.instrument = ins;
		r.inst_length = len;
		r.loop_start = lp;
		r.loop_length = ll;
		r.default_volume = vol;
		r.channel = ch;
		r.period = per;
		r.effect = eff;
		r.param = par;
		return r;
	endfunction

	// True when every byte a voice could read for this header has been written.
	function automatic bit range_written(logic [15:0] base, logic [16:0] len);
		for (int i = 0; i < len; i++) begin
			if (!smem_written[16'(base + i)])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit ins_in_use(logic [4:0] ins);
		for (int v = 0; v < 4; v++) begin
			if (voice_ins[v] == ins)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Plays one voice for one output sample and advances its position.
	function automatic int voice_play(int v);
		int k;
		logic [16:0] ipos;
		logic [33:0] nxt;
		logic signed [7:0] s;
		int prod;
		int q;
		if (voice_per[v] == 0 || voice_ins[v] == 0)
			return 0;
		k = voice_ins[v] - 1;
		if (ins_len[k] == 0)
			return 0;
		ipos = voice_pos[v][32:16];
		if (ipos >= ins_len[k])
			return 0;
		s = smem[16'(ins_base[k] + ipos)];
		prod = int'(s) * int'(voice_vol[v]);
		q = prod / 64;
		nxt = {1'b0, voice_pos[v]} + 34'(voice_inc[v]);
		if (ins_ll[k] > 17'd2) begin
			if (nxt[33:16] >= 18'(ins_lp[k]) + 18'(ins_ll[k]))
				nxt = {1'b0, ins_lp[k], 16'h0000};
		end else if (nxt[33:16] >= 18'(ins_len[k])) begin
			nxt = '0;
			voice_per[v] = '0;
		end
		voice_pos[v] = nxt[32:0];
		return q * 32;
	endfunction

	// Applies one accepted request to the mirrored state; a generate request
	// queues its mix, typed in by the table row where one is given.
	function automatic void mixer_apply(req_t r, bit chk, logic signed [15:0] typed_mix);
		int acc;
		int k;
		case (r.func)
			FUNC_SAMPLE: begin
				smem[r.addr] = r.data_byte;
				smem_written[r.addr] = 1'b1;
			end
			FUNC_HEADER: begin
				if (r.instrument != 0) begin
					k = r.instrument - 1;
					ins_base[k] = r.addr;
					ins_len[k] = r.inst_length;
					ins_lp[k] = r.loop_start;
					ins_ll[k] = r.loop_length;
					ins_vol[k] = (r.default_volume > VOL_MAX) ? VOL_MAX : r.default_volume;
					ins_safe[r.instrument] = range_written(r.addr, r.inst_length);
				end
			end
			FUNC_NOTE: begin
				if (r.instrument != 0) begin
					voice_ins[r.channel] = r.instrument;
					voice_vol[r.channel] = ins_vol[r.instrument - 1];
				end
				if (r.period != 0 && r.effect != EFF_PORTA) begin
					voice_per[r.channel] = r.period;
					voice_pos[r.channel] = '0;
					voice_inc[r.channel] = 24'(INC_NUMERATOR / 24'(r.period));
				end
				if (r.effect == EFF_SET_VOL && r.param <= 8'(VOL_MAX))
					voice_vol[r.channel] = r.param[6:0];
			end
			default: begin
				acc = 0;
				for (int v = 0; v < 4; v++)
					acc += voice_play(v);
				if (acc > 32767)
					acc = 32767;
				if (acc < -32768)
					acc = -32768;
				mix_expect_q.push_back(chk ? typed_mix : 16'(acc));
			end
		endcase
	endfunction

	// Picks one random request. Voices only ever hold instruments whose bytes are
	// all written, so no voice can read an unwritten sample byte.
	function automatic req_t rand_req();
		req_t r;
		int pick;
		int roll;
		r = mk_req(FUNC_GEN, 16'($urandom), 8'($urandom), 5'($urandom), 17'($urandom),
			17'($urandom), 17'($urandom), 7'($urandom), 2'($urandom), 12'($urandom),
			4'($urandom), 8'($urandom));
		pick = $urandom_range(99);
		if (pick < 12) begin
			r.func = FUNC_SAMPLE;
		end else if (pick < 22) begin
			r.func = FUNC_HEADER;
			if ($urandom_range(19) == 0)
				r.instrument = 5'd0;
			roll = $urandom_range(19);
			if (roll == 0) begin
				// Wide header: lengths and loop fields anywhere from 0 to 131070.
				r.inst_length = 17'($urandom_range(131070));
				r.loop_start = 17'($urandom_range(131070));
				r.loop_length = 17'($urandom_range(131070));
			end else begin
				r.addr = ($urandom_range(3) == 0) ? 16'hFFC0 + 16'($urandom_range(63))
					: 16'($urandom_range(255));
				r.inst_length = 17'($urandom_range(1, 256));
				r.loop_start = 17'($urandom_range(0, r.inst_length + 8));
				r.loop_length = ($urandom_range(9) < 4) ? 17'($urandom_range(2))
					: 17'($urandom_range(3, r.inst_length + 8));
			end
			if (r.instrument != 0 && ins_in_use(r.instrument)
					&& !range_written(r.addr, r.inst_length)) begin
				r.addr = 16'd0;
				r.inst_length = 17'd1;
			end
		end else if (pick < 45) begin
			r.func = FUNC_NOTE;
			if ($urandom_range(4) == 0 || !ins_safe[r.instrument])
				r.instrument = 5'd0;
			roll = $urandom_range(9);
			if (roll < 3)
				r.period = 12'd0;
			else if (roll < 7)
				r.period = 12'($urandom_range(100, 4095));
			else if (roll < 9)
				r.period = 12'($urandom_range(1, 99));
			else
				r.period = 12'($urandom_range(1, 4095));
			roll = $urandom_range(9);
			if (roll < 2)
				r.effect = EFF_PORTA;
			else if (roll < 5) begin
				r.effect = EFF_SET_VOL;
				if ($urandom_range(1))
					r.param = 8'($urandom_range(64));
			end
		end
		return r;
	endfunction

	// Offers one request and holds it until accepted, then updates the predictor.
	task automatic send_req(req_t r, bit chk, logic signed [15:0] typed_mix);
		int gap;
		gap = (!quiet && $urandom_range(99) < 24) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		drv <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		mixer_apply(r, chk, typed_mix);
		items_sent++;
		case (r.func)
			FUNC_SAMPLE: bytes_sent++;
			FUNC_HEADER: headers_sent++;
			FUNC_NOTE: notes_sent++;
			default: ;
		endcase
	endtask

	// Receiver pacing: random stalls, none in the quiet stretch, and the long
	// hold-off on top.
	initial begin
		forever begin
			@(posedge clk);
			out_stall <= hold_off || (!quiet && $urandom_range(99) < 24);
		end
	end

	// Long hold-off in the middle of the random part; the sender keeps offering
	// requests, so the queue fills and the block must stall its input.
	initial begin
		wait (items_sent >= 1000);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) begin
			@(posedge clk);
			if (in_stall)
				stall_cycles++;
		end
		hold_off <= 1'b0;
	end

	// Output checker: each accepted mix is compared with the oldest expectation.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (mix_expect_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected mixed sample %0d with nothing pending", mixed_sample);
			end else begin
				want = mix_expect_q.pop_front();
				mixes_checked++;
				if (mixed_sample !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Mixed sample mismatch: expected %0d, got %0d",
							want, mixed_sample);
				end
			end
		end
	end

	initial begin
		int guard;
		for (int i = 0; i < 65536; i++) begin
			smem[i] = '0;
			smem_written[i] = 1'b0;
		end
		for (int k = 0; k < 32; k++) begin
			ins_base[k] = '0;
			ins_len[k] = '0;
			ins_lp[k] = '0;
			ins_ll[k] = '0;
			ins_vol[k] = '0;
			ins_safe[k] = 1'b1;
		end
		for (int v = 0; v < 4; v++) begin
			voice_per[v] = '0;
			voice_ins[v] = '0;
			voice_vol[v] = '0;
			voice_pos[v] = '0;
			voice_inc[v] = '0;
		end

		// Directed table. After reset every voice is silent. A full-volume note
		// on a byte of 127 gives 127 * 32. Default volume above 64 is stored as
		// 64, header writes to instrument 0 are dropped, portamento leaves the
		// note running, set-volume above 64 is ignored, an unlooped voice stops
		// at its end, and a header may wrap past the top of sample memory.
		dir_tab[0]  = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'sd0};
		dir_tab[1]  = '{mk_req(FUNC_SAMPLE, 16'd0, 8'h7F, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_tab[2]  = '{mk_req(FUNC_SAMPLE, 16'd1, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_tab[3]  = '{mk_req(FUNC_SAMPLE, 16'hFFFF, 8'h55, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0};
		dir_tab[4]  = '{mk_req(FUNC_HEADER, 16'hFFFF, 0, 5'd0, 17'd131070, 17'd131070,
			17'd131070, 7'd127, 0, 0, 0, 0), 0, 0};
		dir_tab[5]  = '{mk_req(FUNC_HEADER, 16'd0, 0, 5'd1, 17'd2, 0, 0, 7'd127, 0, 0, 0, 0),
			0, 0};
		dir_tab[6]  = '{mk_req(FUNC_HEADER, 16'hFFFF, 0, 5'd31, 17'd2, 0, 17'd131070,
			7'd64, 0, 0, 0, 0), 0, 0};
		dir_tab[7]  = '{mk_req(FUNC_NOTE, 0, 0, 5'd1, 0, 0, 0, 0, 2'd0, 12'd4095, 4'd0, 0),
			0, 0};
		dir_tab[8]  = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'sd4064};
		dir_tab[9]  = '{mk_req(FUNC_NOTE, 0, 0, 5'd31, 0, 0, 0, 0, 2'd3, 12'd1, EFF_SET_VOL,
			8'd64), 0, 0};
		dir_tab[10] = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_tab[11] = '{mk_req(FUNC_NOTE, 0, 0, 5'd1, 0, 0, 0, 0, 2'd1, 12'd0, EFF_SET_VOL,
			8'd65), 0, 0};
		dir_tab[12] = '{mk_req(FUNC_NOTE, 0, 0, 5'd0, 0, 0, 0, 0, 2'd2, 12'd200, EFF_PORTA,
			0), 0, 0};
		dir_tab[13] = '{mk_req(FUNC_NOTE, 0, 0, 5'd0, 0, 0, 0, 0, 2'd0, 12'd4095, EFF_PORTA,
			0), 0, 0};
		dir_tab[14] = '{mk_req(FUNC_NOTE, 0, 0, 5'd1, 0, 0, 0, 0, 2'd1, 12'd1, 4'hF,
			8'hFF), 0, 0};
		dir_tab[15] = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_tab[16] = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_tab[17] = '{mk_req(FUNC_HEADER, 16'd0, 0, 5'd30, 17'd131070, 17'd131070,
			17'd131070, 7'd64, 0, 0, 0, 0), 0, 0};
		dir_tab[18] = '{mk_req(FUNC_NOTE, 0, 0, 5'd1, 0, 0, 0, 0, 2'd2, 12'd2000, EFF_SET_VOL,
			8'd0), 0, 0};
		dir_tab[19] = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_tab[20] = '{mk_req(FUNC_GEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i].r, dir_tab[i].chk, dir_tab[i].mix);

		// Sample pool that random headers point into: the bottom 256 bytes and
		// the top 64, so that some instruments wrap around the address space.
		for (int a = 0; a < 256; a++)
			send_req(mk_req(FUNC_SAMPLE, 16'(a), 8'($urandom), 0, 0, 0, 0, 0, 0, 0, 0, 0),
				0, 0);
		for (int a = 16'hFFC0; a <= 16'hFFFF; a++)
			send_req(mk_req(FUNC_SAMPLE, 16'(a), 8'($urandom), 0, 0, 0, 0, 0, 0, 0, 0, 0),
				0, 0);

		for (int n = 0; n < RAND_ITEMS - 320; n++) begin
			quiet = (n >= 300 && n < 600);
			send_req(rand_req(), 0, 0);
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		guard = 0;
		while (mix_expect_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);

		$display("Run covered %0d requests: %0d sample bytes, %0d headers, %0d notes.",
			items_sent, bytes_sent, headers_sent, notes_sent);
		$display("Checked %0d mixed samples; input stalled %0d cycles during the hold-off.",
			mixes_checked, stall_cycles);
		if (fail_count == 0 && mix_expect_q.size() == 0) begin
			$display("mod_four_channel_sample_mixer_top_tb OK");
		end else begin
			$display("mod_four_channel_sample_mixer_top_tb NOT OK");
		end
		$finish;
	end

endmodule
